>>> sv/zcdr_pkg.sv
`timescale 1ns / 1ps

package zcdr_pkg;

    // Fixed record header
    localparam int HDR_LEN = 46;
    localparam int POS_W   = 6;
    localparam int SKIP_W  = 18;
    localparam logic [31:0] HDR_SIG = 32'h0201_4b50;

    // Byte offsets of the header fields
    localparam int OFS_SIG     = 'h00;
    localparam int OFS_FLAGS   = 'h08;
    localparam int OFS_METHOD  = 'h0a;
    localparam int OFS_TIME    = 'h0c;
    localparam int OFS_DATE    = 'h0e;
    localparam int OFS_CRC     = 'h10;
    localparam int OFS_PACKED  = 'h14;
    localparam int OFS_PLAIN   = 'h18;
    localparam int OFS_NAMELEN = 'h1c;
    localparam int OFS_XTRALEN = 'h1e;
    localparam int OFS_CMNTLEN = 'h20;
    localparam int OFS_LHDR    = 'h2a;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HDR_LEN - 1);

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADSIG = 2'd1;
    localparam logic [1:0] ST_TRUNC  = 2'd2;

    // Parser phase codes
    localparam logic PH_HDR  = 1'b0;
    localparam logic PH_SKIP = 1'b1;

    localparam int OUT_DATA_W = 224;

    typedef logic [7:0] byte_t;

    // Decoded record fields, packed in result tdata order (first member in high bits)
    typedef struct packed {
        logic [31:0] header_offset;
        logic [15:0] name_length;
        logic [31:0] plain_size;
        logic [31:0] packed_size;
        logic [31:0] crc_value;
        logic [15:0] mod_date;
        logic [15:0] mod_time;
        logic [15:0] compression_method;
        logic [15:0] flag_bits;
        logic [15:0] record_index;
    } rec_fields_t;

endpackage

>>> sv/zip_central_dir_record_parser.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake         Payload
// s_*       in   s_tvalid/tready   tdata = data_byte[7:0], tlast = last_byte
// m_*       out  m_tvalid/tready   tuser = status, tdata = record fields, tlast = all_done
// cfg_*     in   cfg_we            cfg_data = entry_count
//
// One byte is taken every cycle unless m_tready stalls. A byte is held in the input
// register and its result, if any, is then loaded into the result register on m_*.
// The rate is set by the single state update per byte (header capture / skip count).
// Reset (rst_n low, async) clears all control state; header bytes are not cleared.
// A stalled m_tready holds the result register; the input register then fills and
// s_tready drops only once both are occupied.

module zip_central_dir_record_parser
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_we,
    input  logic [15:0]  cfg_data,     // entry_count
    // byte stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,      // data_byte[7:0]
    input  logic         s_tlast,      // last_byte
    // record results out
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [223:0] m_tdata,      // record_index, flag_bits, compression_method,
                                       // mod_time, mod_date, crc_value, packed_size,
                                       // plain_size, name_length, header_offset
    output logic [1:0]   m_tuser,      // status
    output logic         m_tlast       // all_done
);

    // ---------------- input register ----------------
    logic                in_valid_reg;
    zcdr_pkg::byte_t     in_byte_reg;
    logic                in_last_reg;

    logic [15:0]         entry_count_reg;

    // ---------------- parser state ----------------
    logic                          phase_reg, phase_next;
    logic [zcdr_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [zcdr_pkg::SKIP_W-1:0]   skip_reg, skip_next;
    logic [15:0]                   done_reg, done_next;
    logic                          stopped_reg, stopped_next;
    zcdr_pkg::byte_t               hdr_reg [0:zcdr_pkg::HDR_LEN-1];
    zcdr_pkg::byte_t               hdr_view [0:zcdr_pkg::HDR_LEN-1];

    // ---------------- result register ----------------
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    out_status_reg;
    zcdr_pkg::rec_fields_t         out_fields_reg;
    logic                          out_last_reg;

    logic                          proc_en;
    logic                          active;
    logic                          res_load;
    logic [1:0]                    res_status;
    zcdr_pkg::rec_fields_t         res_fields;
    logic                          res_last;
    zcdr_pkg::rec_fields_t         dec_fields;
    logic [31:0]                   sig_word;
    logic [zcdr_pkg::SKIP_W-1:0]   trail_len;
    logic [zcdr_pkg::SKIP_W-1:0]   skip_dec;
    logic                          final_rec;

    // Byte in the input register is processed when the result slot is free
    assign proc_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign active   = proc_en && !stopped_reg && (done_reg < entry_count_reg);
    assign s_tready = !in_valid_reg || proc_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    // Header byte store; each entry written at its own position
    always_ff @(posedge clk)
    begin
        if (active && (phase_reg == zcdr_pkg::PH_HDR))
        begin
            hdr_reg[pos_reg] <= in_byte_reg;
        end
    end

    // The 46th byte is still in flight when the header closes: bypass it
    always_comb
    begin
        for (int i = 0; i < zcdr_pkg::HDR_LEN; i++)
        begin
            hdr_view[i] = hdr_reg[i];
        end
        if (phase_reg == zcdr_pkg::PH_HDR)
        begin
            hdr_view[zcdr_pkg::HDR_LEN-1] = in_byte_reg;
        end
    end

    // Little-endian field extraction
    always_comb
    begin
        sig_word = {hdr_view[zcdr_pkg::OFS_SIG+3], hdr_view[zcdr_pkg::OFS_SIG+2],
                    hdr_view[zcdr_pkg::OFS_SIG+1], hdr_view[zcdr_pkg::OFS_SIG]};
        dec_fields.record_index       = done_reg;
        dec_fields.flag_bits          = {hdr_view[zcdr_pkg::OFS_FLAGS+1],
                                         hdr_view[zcdr_pkg::OFS_FLAGS]};
        dec_fields.compression_method = {hdr_view[zcdr_pkg::OFS_METHOD+1],
                                         hdr_view[zcdr_pkg::OFS_METHOD]};
        dec_fields.mod_time           = {hdr_view[zcdr_pkg::OFS_TIME+1],
                                         hdr_view[zcdr_pkg::OFS_TIME]};
        dec_fields.mod_date           = {hdr_view[zcdr_pkg::OFS_DATE+1],
                                         hdr_view[zcdr_pkg::OFS_DATE]};
        dec_fields.crc_value          = {hdr_view[zcdr_pkg::OFS_CRC+3],
                                         hdr_view[zcdr_pkg::OFS_CRC+2],
                                         hdr_view[zcdr_pkg::OFS_CRC+1],
                                         hdr_view[zcdr_pkg::OFS_CRC]};
        dec_fields.packed_size        = {hdr_view[zcdr_pkg::OFS_PACKED+3],
                                         hdr_view[zcdr_pkg::OFS_PACKED+2],
                                         hdr_view[zcdr_pkg::OFS_PACKED+1],
                                         hdr_view[zcdr_pkg::OFS_PACKED]};
        dec_fields.plain_size         = {hdr_view[zcdr_pkg::OFS_PLAIN+3],
                                         hdr_view[zcdr_pkg::OFS_PLAIN+2],
                                         hdr_view[zcdr_pkg::OFS_PLAIN+1],
                                         hdr_view[zcdr_pkg::OFS_PLAIN]};
        dec_fields.name_length        = {hdr_view[zcdr_pkg::OFS_NAMELEN+1],
                                         hdr_view[zcdr_pkg::OFS_NAMELEN]};
        dec_fields.header_offset      = {hdr_view[zcdr_pkg::OFS_LHDR+3],
                                         hdr_view[zcdr_pkg::OFS_LHDR+2],
                                         hdr_view[zcdr_pkg::OFS_LHDR+1],
                                         hdr_view[zcdr_pkg::OFS_LHDR]};

        // name + extra + comment lengths
        trail_len = {2'b00, hdr_view[zcdr_pkg::OFS_NAMELEN+1],
                            hdr_view[zcdr_pkg::OFS_NAMELEN]}
                  + {2'b00, hdr_view[zcdr_pkg::OFS_XTRALEN+1],
                            hdr_view[zcdr_pkg::OFS_XTRALEN]}
                  + {2'b00, hdr_view[zcdr_pkg::OFS_CMNTLEN+1],
                            hdr_view[zcdr_pkg::OFS_CMNTLEN]};
    end

    assign final_rec = ({1'b0, done_reg} + 17'd1) == {1'b0, entry_count_reg};
    assign skip_dec  = (skip_reg != '0) ? (skip_reg - 1'b1) : skip_reg;

    // Per-byte state update and result formation
    always_comb
    begin
        logic do_finish;
        logic do_error;
        logic [1:0] err_code;

        phase_next   = phase_reg;
        pos_next     = pos_reg;
        skip_next    = skip_reg;
        done_next    = done_reg;
        stopped_next = stopped_reg;
        do_finish    = 1'b0;
        do_error     = 1'b0;
        err_code     = zcdr_pkg::ST_TRUNC;

        if (active)
        begin
            if (phase_reg == zcdr_pkg::PH_HDR)
            begin
                if (pos_reg != zcdr_pkg::POS_LAST)
                begin
                    pos_next = pos_reg + 1'b1;
                    do_error = in_last_reg;
                end
                else if (sig_word != zcdr_pkg::HDR_SIG)
                begin
                    do_error = 1'b1;
                    err_code = zcdr_pkg::ST_BADSIG;
                end
                else if (trail_len == '0)
                begin
                    do_finish = 1'b1;
                end
                else
                begin
                    phase_next = zcdr_pkg::PH_SKIP;
                    pos_next   = '0;
                    skip_next  = trail_len;
                    do_error   = in_last_reg;
                end
            end
            else
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    do_finish = 1'b1;
                end
                else
                begin
                    do_error = in_last_reg;
                end
            end

            // stream end before the expected record count
            if (do_finish && in_last_reg && !final_rec)
            begin
                do_finish = 1'b0;
                do_error  = 1'b1;
                err_code  = zcdr_pkg::ST_TRUNC;
            end
        end

        res_load   = do_finish || do_error;
        res_status = zcdr_pkg::ST_OK;
        res_fields = dec_fields;
        res_last   = final_rec;

        if (do_error)
        begin
            stopped_next            = 1'b1;
            res_status              = err_code;
            res_fields              = '0;
            res_fields.record_index = done_reg;
            res_last                = 1'b0;
        end
        else if (do_finish)
        begin
            done_next  = done_reg + 1'b1;
            phase_next = zcdr_pkg::PH_HDR;
            pos_next   = '0;
            skip_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= zcdr_pkg::PH_HDR;
            pos_reg     <= '0;
            skip_reg    <= '0;
            done_reg    <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            skip_reg    <= skip_next;
            done_reg    <= done_next;
            stopped_reg <= stopped_next;
        end
    end

    // ---------------- result register ----------------
    assign out_valid_next = res_load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_status_reg <= res_status;
            out_fields_reg <= res_fields;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = zcdr_pkg::OUT_DATA_W'(out_fields_reg);
    assign m_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != zcdr_pkg::ST_OK)) |-> stopped_reg)
        else $error("error result without stopped parser");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != zcdr_pkg::ST_OK)) |-> ((m_tdata[223:16] == '0) && !m_tlast))
        else $error("error result carries record fields");

    a_no_result_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> !res_load)
        else $error("result produced after stop");

    // a stream end on the closing trailer byte leaves the count at zero once stopped
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == zcdr_pkg::PH_SKIP) && !stopped_reg) |-> (skip_reg != '0))
        else $error("skip phase with empty skip count");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= zcdr_pkg::POS_LAST)
        else $error("header position out of range");

endmodule

>>> tb/sv/tb_zip_central_dir_record_parser.sv
`timescale 1ns / 1ps

module tb_zip_central_dir_record_parser;

    // Header fill patterns for record building
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    // How the run is ended; errors are sticky, so only one per run
    localparam int END_BADSIG    = 0;
    localparam int END_TRUNC_HDR = 1;
    localparam int END_TRUNC_SKP = 2;
    localparam int END_EARLY     = 3;

    localparam int NO_MARK    = -1;
    localparam int DRAIN_GAP  = 8;      // > request-to-result path (input and result registers)
    localparam int MAX_REPORT = 10;

    typedef struct {
        logic [1:0]            status;
        zcdr_pkg::rec_fields_t fields;
        logic                  all_done;
    } record_result_t;

    // Tracks parser state per accepted byte and holds the results (decoded records
    // and errors) still owed by the block.
    class central_dir_board;
        logic [15:0]     entry_count;
        logic            cur_phase;
        logic [5:0]      hdr_pos;
        zcdr_pkg::byte_t hdr [zcdr_pkg::HDR_LEN];
        logic [17:0]     skip_left;
        logic [15:0]     records_done;
        logic            halted;
        record_result_t  owed_records [$];
        int              checked;
        int              mismatches;

        function new();
            entry_count  = '0;
            cur_phase    = zcdr_pkg::PH_HDR;
            hdr_pos      = '0;
            skip_left    = '0;
            records_done = '0;
            halted       = 1'b0;
            checked      = 0;
            mismatches   = 0;
            foreach (hdr[i])
                hdr[i] = '0;
        endfunction

        function logic [15:0] word16(int at);
            return {hdr[at + 1], hdr[at]};
        endfunction

        function logic [31:0] word32(int at);
            return {word16(at + 2), word16(at)};
        endfunction

        function void raise_error(logic [1:0] code);
            record_result_t r;
            r.status              = code;
            r.fields              = '0;
            r.fields.record_index = records_done;
            r.all_done            = 1'b0;
            owed_records.push_back(r);
            halted = 1'b1;
        endfunction

        function void close_record(logic last);
            record_result_t r;
            logic           final_one;
            final_one = ({1'b0, records_done} + 17'd1) == {1'b0, entry_count};
            if (last && !final_one)
            begin
                raise_error(zcdr_pkg::ST_TRUNC);
                return;
            end
            r.status                    = zcdr_pkg::ST_OK;
            r.all_done                  = final_one;
            r.fields.record_index       = records_done;
            r.fields.flag_bits          = word16(zcdr_pkg::OFS_FLAGS);
            r.fields.compression_method = word16(zcdr_pkg::OFS_METHOD);
            r.fields.mod_time           = word16(zcdr_pkg::OFS_TIME);
            r.fields.mod_date           = word16(zcdr_pkg::OFS_DATE);
            r.fields.crc_value          = word32(zcdr_pkg::OFS_CRC);
            r.fields.packed_size        = word32(zcdr_pkg::OFS_PACKED);
            r.fields.plain_size         = word32(zcdr_pkg::OFS_PLAIN);
            r.fields.name_length        = word16(zcdr_pkg::OFS_NAMELEN);
            r.fields.header_offset      = word32(zcdr_pkg::OFS_LHDR);
            owed_records.push_back(r);
            records_done++;
            cur_phase = zcdr_pkg::PH_HDR;
            hdr_pos   = '0;
            skip_left = '0;
        endfunction

        // One accepted stream byte
        function void take_byte(zcdr_pkg::byte_t b, logic last);
            if (halted || records_done >= entry_count)
                return;
            if (cur_phase == zcdr_pkg::PH_HDR)
            begin
                hdr[hdr_pos] = b;
                if (hdr_pos != zcdr_pkg::POS_LAST)
                begin
                    hdr_pos++;
                    if (last)
                        raise_error(zcdr_pkg::ST_TRUNC);
                    return;
                end
                // signature wins over a stream end on the same byte
                if (word32(zcdr_pkg::OFS_SIG) != zcdr_pkg::HDR_SIG)
                begin
                    raise_error(zcdr_pkg::ST_BADSIG);
                    return;
                end
                skip_left = word16(zcdr_pkg::OFS_NAMELEN) + word16(zcdr_pkg::OFS_XTRALEN)
                          + word16(zcdr_pkg::OFS_CMNTLEN);
                if (skip_left == 0)
                begin
                    close_record(last);
                    return;
                end
                cur_phase = zcdr_pkg::PH_SKIP;
                hdr_pos   = '0;
                if (last)
                    raise_error(zcdr_pkg::ST_TRUNC);
                return;
            end
            if (skip_left > 0)
                skip_left--;
            if (skip_left == 0)
                close_record(last);
            else if (last)
                raise_error(zcdr_pkg::ST_TRUNC);
        endfunction

        function void compare_field(string name, int idx, logic [31:0] want, logic [31:0] got);
            if (want === got)
                return;
            mismatches++;
            if (mismatches <= MAX_REPORT)
                $display("%0t: record %0d %s mismatch: expected %h, got %h",
                         $time, idx, name, want, got);
        endfunction

        // One accepted result from the block
        function void check_record(logic [1:0] status, logic [223:0] data, logic done_flag);
            record_result_t        want;
            zcdr_pkg::rec_fields_t got;
            got = data;
            if (owed_records.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("%0t: unexpected result, status %0d record %0d",
                             $time, status, got.record_index);
                return;
            end
            want = owed_records.pop_front();
            checked++;
            compare_field("status", checked, want.status, status);
            compare_field("record_index", checked, want.fields.record_index, got.record_index);
            compare_field("flag_bits", checked, want.fields.flag_bits, got.flag_bits);
            compare_field("compression_method", checked,
                          want.fields.compression_method, got.compression_method);
            compare_field("mod_time", checked, want.fields.mod_time, got.mod_time);
            compare_field("mod_date", checked, want.fields.mod_date, got.mod_date);
            compare_field("crc_value", checked, want.fields.crc_value, got.crc_value);
            compare_field("packed_size", checked, want.fields.packed_size, got.packed_size);
            compare_field("plain_size", checked, want.fields.plain_size, got.plain_size);
            compare_field("name_length", checked, want.fields.name_length, got.name_length);
            compare_field("header_offset", checked,
                          want.fields.header_offset, got.header_offset);
            compare_field("all_done", checked, want.all_done, done_flag);
        endfunction
    endclass

    logic           clk      = 1'b0;
    logic           rst_n    = 1'b0;
    logic           cfg_we   = 1'b0;
    logic [15:0]    cfg_data = '0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [7:0]     s_tdata  = '0;     // data_byte[7:0]
    logic           s_tlast  = 1'b0;   // last_byte
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [223:0]   m_tdata;           // record_index, flag_bits, compression_method,
                                       // mod_time, mod_date, crc_value, packed_size,
                                       // plain_size, name_length, header_offset
    logic [1:0]     m_tuser;           // status
    logic           m_tlast;           // all_done

    central_dir_board board = new;

    // Random idling on both sides; cleared for the calm stretches
    bit    gaps_on      = 1'b1;
    int    record_bytes = 0;
    string end_case     = "none";

    zip_central_dir_record_parser dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hang guard, far beyond the slowest legal run (a few thousand stream bytes)
    initial
    begin
        #2_000_000;
        $display("Timeout: %0d results still owed", board.owed_records.size());
        $display("TEST FAILED");
        $finish;
    end

    // Result sink: stalls about a quarter of the cycles unless calm
    always @(posedge clk)
        m_tready <= !gaps_on || ($urandom_range(99) >= 25);

    // Outputs are sampled in the active region right after the edge, i.e. the
    // values that the flops saw at that edge.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_record(m_tuser, m_tdata, m_tlast);

    // Offers one byte request and holds it until taken; the prediction is updated
    // at the accepting edge so that drain() never misses an in-flight request.
    task automatic send_byte(input zcdr_pkg::byte_t b, input logic last);
        while (gaps_on && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        board.take_byte(b, last);
    endtask

    // Wait out every owed result, then the pipeline latency, before a register write
    task automatic drain();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge clk);
        while (board.owed_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_count(input logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        board.entry_count = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Bytes the parser must ignore (count reached, or stopped)
    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_byte(zcdr_pkg::byte_t'($urandom), logic'($urandom_range(1)));
    endtask

    // Drop the count mid-record, feed ignored bytes, then restore it
    task automatic park_and_resume();
        logic [15:0] saved;
        saved = board.entry_count;
        drain();
        write_count(16'($urandom_range(board.records_done)));
        send_noise($urandom_range(6, 1));
        drain();
        write_count(saved);
    endtask

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 16'd0;
        if (r < 90)
            return 16'($urandom_range(4, 1));
        return 16'($urandom_range(60, 5));
    endfunction

    // One directory record: 46-byte header then name/extra/comment filler.
    // last_at: byte index carrying tlast; pause_at: index before which the count
    // is parked; flip_bit: signature bit to corrupt.
    task automatic send_record(input int fill, input logic [15:0] nlen, input logic [15:0] xlen,
                               input logic [15:0] clen, input int last_at, input int pause_at,
                               input int flip_bit);
        zcdr_pkg::byte_t hdr [zcdr_pkg::HDR_LEN];
        int              total;
        zcdr_pkg::byte_t b;
        foreach (hdr[i])
            case (fill)
                FILL_ZERO: hdr[i] = 8'h00;
                FILL_ONES: hdr[i] = 8'hff;
                default:   hdr[i] = zcdr_pkg::byte_t'($urandom);
            endcase
        {hdr[zcdr_pkg::OFS_SIG + 3], hdr[zcdr_pkg::OFS_SIG + 2],
         hdr[zcdr_pkg::OFS_SIG + 1], hdr[zcdr_pkg::OFS_SIG]} = zcdr_pkg::HDR_SIG;
        {hdr[zcdr_pkg::OFS_NAMELEN + 1], hdr[zcdr_pkg::OFS_NAMELEN]} = nlen;
        {hdr[zcdr_pkg::OFS_XTRALEN + 1], hdr[zcdr_pkg::OFS_XTRALEN]} = xlen;
        {hdr[zcdr_pkg::OFS_CMNTLEN + 1], hdr[zcdr_pkg::OFS_CMNTLEN]} = clen;
        if (flip_bit >= 0)
            hdr[zcdr_pkg::OFS_SIG + flip_bit / 8] ^= zcdr_pkg::byte_t'(1 << (flip_bit % 8));
        total = zcdr_pkg::HDR_LEN + int'(nlen) + int'(xlen) + int'(clen);
        for (int i = 0; i < total; i++)
        begin
            if (i == pause_at)
                park_and_resume();
            b = (i < zcdr_pkg::HDR_LEN) ? hdr[i] : zcdr_pkg::byte_t'($urandom);
            send_byte(b, i == last_at);
            record_bytes++;
        end
    endtask

    initial
    begin
        int          n;
        int          start_bytes;
        int          phase_no;
        int          last_at;
        int          pause_at;
        int          goods;
        int          kind;
        int          total;
        logic [15:0] target;
        logic [15:0] nlen;
        logic [15:0] xlen;
        logic [15:0] clen;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // count of zero: everything is ignored, stream-end marks included
        write_count(16'd0);
        send_noise(4);
        send_byte(8'hff, 1'b1);
        drain();

        write_count(16'd6);
        // empty trailer, all-zero fields: record closes on its 46th byte
        send_record(FILL_ZERO, 16'd0, 16'd0, 16'd0, NO_MARK, NO_MARK, NO_MARK);
        // each length word alone
        send_record(FILL_RANDOM, 16'd1, 16'd0, 16'd0, NO_MARK, NO_MARK, NO_MARK);
        send_record(FILL_RANDOM, 16'd0, 16'd2, 16'd0, NO_MARK, NO_MARK, NO_MARK);
        send_record(FILL_RANDOM, 16'd0, 16'd0, 16'd3, NO_MARK, NO_MARK, NO_MARK);
        // all-ones fields with all three lengths set; run at full rate
        gaps_on = 1'b0;
        send_record(FILL_ONES, 16'd3, 16'd2, 16'd1, NO_MARK, NO_MARK, NO_MARK);
        gaps_on = 1'b1;
        // final expected record carries the stream end: clean all_done
        nlen  = pick_len();
        total = zcdr_pkg::HDR_LEN + int'(nlen) + 2;
        send_record(FILL_RANDOM, nlen, 16'd1, 16'd1, total - 1, NO_MARK, NO_MARK);
        // count reached: trailing bytes are dropped
        send_noise(5);
        drain();

        // widest count
        write_count(16'hffff);
        send_record(FILL_RANDOM, 16'd2, 16'd0, 16'd1, NO_MARK, NO_MARK, NO_MARK);
        send_record(FILL_ZERO, 16'd0, 16'd0, 16'd0, NO_MARK, NO_MARK, NO_MARK);
        drain();

        // ---- random part: well-formed runs of records, random content ----
        start_bytes = record_bytes;
        phase_no    = 0;
        while (record_bytes - start_bytes < 900)
        begin
            n       = $urandom_range(4, 1);
            gaps_on = !(phase_no >= 2 && phase_no < 4);
            target  = ($urandom_range(9) == 0) ? 16'hffff : board.records_done + 16'(n);
            write_count(target);
            for (int k = 0; k < n; k++)
            begin
                nlen     = pick_len();
                xlen     = pick_len();
                clen     = pick_len();
                total    = zcdr_pkg::HDR_LEN + int'(nlen) + int'(xlen) + int'(clen);
                last_at  = (k == n - 1 && target != 16'hffff && $urandom_range(1) == 1)
                           ? total - 1 : NO_MARK;
                pause_at = ($urandom_range(99) < 12) ? $urandom_range(total - 1) : NO_MARK;
                send_record(FILL_RANDOM, nlen, xlen, clen, last_at, pause_at, NO_MARK);
            end
            if (target != 16'hffff && $urandom_range(2) == 0)
                send_noise($urandom_range(8, 1));
            drain();
            phase_no++;
        end

        // ---- broken stream at the end: the error sticks until reset ----
        gaps_on = 1'b1;
        goods   = $urandom_range(1);
        target  = ($urandom_range(3) == 0) ? 16'hffff
                  : board.records_done + 16'(goods) + 16'($urandom_range(3, 2));
        write_count(target);
        for (int k = 0; k < goods; k++)
            send_record(FILL_RANDOM, pick_len(), pick_len(), pick_len(),
                        NO_MARK, NO_MARK, NO_MARK);
        kind = $urandom_range(END_EARLY, END_BADSIG);
        nlen = pick_len() + 16'd1;
        xlen = pick_len();
        clen = pick_len();
        total = zcdr_pkg::HDR_LEN + int'(nlen) + int'(xlen) + int'(clen);
        case (kind)
            END_BADSIG:
            begin
                end_case = "bad signature";
                send_record(FILL_RANDOM, nlen, xlen, clen,
                            ($urandom_range(1) == 1) ? zcdr_pkg::HDR_LEN - 1 : NO_MARK,
                            NO_MARK, $urandom_range(31));
            end
            END_TRUNC_HDR:
            begin
                end_case = "stream end inside header";
                send_record(FILL_RANDOM, nlen, xlen, clen,
                            $urandom_range(zcdr_pkg::HDR_LEN - 2), NO_MARK, NO_MARK);
            end
            END_TRUNC_SKP:
            begin
                end_case = "stream end inside trailer";
                send_record(FILL_RANDOM, nlen, xlen, clen,
                            $urandom_range(total - 2, zcdr_pkg::HDR_LEN - 1),
                            NO_MARK, NO_MARK);
            end
            default:
            begin
                end_case = "stream end with records missing";
                send_record(FILL_RANDOM, nlen, xlen, clen, total - 1, NO_MARK, NO_MARK);
            end
        endcase
        // stopped: nothing more may come out, even a clean-looking record
        send_noise($urandom_range(8, 2));
        send_record(FILL_RANDOM, 16'd0, 16'd0, 16'd0, NO_MARK, NO_MARK, NO_MARK);
        drain();

        $display("Covered %0d results over %0d record bytes, counts 0 to 65535, parked counts",
                 board.checked, record_bytes);
        $display("Run ended on: %s", end_case);
        if (board.owed_records.size() != 0)
            $display("%0d results never arrived", board.owed_records.size());
        if (board.mismatches == 0 && board.owed_records.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
sv/zcdr_pkg.sv
sv/zip_central_dir_record_parser.sv
tb/sv/tb_zip_central_dir_record_parser.sv
